// File: hdl/vfc_pkg.sv
// Shared types, command codes and constants for the voxel face connectivity block.
// No dependencies; used by vfc_ctrl, voxel_face_connectivity and the testbench.
package vfc_pkg;

    localparam int CUBE_WIDTH_DEF = 16;
    localparam int POS_W          = 4;
    localparam int TYPE_W         = 8;
    localparam int MASK_W         = 15;
    localparam int AIR_W          = 13;
    localparam int FACES          = 6;

    localparam logic [MASK_W-1:0] ALL_PAIRS = 15'h7FFF;

    localparam logic [1:0] CMD_WRITE   = 2'd0;
    localparam logic [1:0] CMD_READ    = 2'd1;
    localparam logic [1:0] CMD_COMPUTE = 2'd2;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [POS_W-1:0]  pos_z;
        logic [TYPE_W-1:0] block_type;
    } t_in_beat;

    typedef struct packed {
        logic [TYPE_W-1:0] read_type;
        logic [MASK_W-1:0] pass_mask;
        logic [AIR_W-1:0]  air_total;
    } t_out_beat;

    function automatic logic [MASK_W-1:0] pair_bits(input logic [FACES-1:0] faces);
        logic [MASK_W-1:0] m;
        int                k;
        m = '0;
        k = 0;
        for (int a = 0; a < FACES - 1; a++) begin
            for (int b = a + 1; b < FACES; b++) begin
                m[k] = faces[a] & faces[b];
                k    = k + 1;
            end
        end
        return m;
    endfunction

endpackage

// File: hdl/vfc_ram.sv
// Simple dual-port synchronous RAM: one write port, one registered read port.
// Depends on nothing; instantiated by vfc_ctrl.
module vfc_ram #(
    parameter int DW = 8,
    parameter int AW = 12
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/vfc_ctrl.sv
// Command sequencer and flood-fill walker over the block, visited and stack RAMs.
// Depends on vfc_pkg and vfc_ram.
module vfc_ctrl #(
    parameter int CUBE_WIDTH = vfc_pkg::CUBE_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  vfc_pkg::t_in_beat   i_beat,
    input  logic                i_out_free,
    output logic                o_idle,
    output logic                o_done,
    output vfc_pkg::t_out_beat  o_result
);

    localparam int W    = CUBE_WIDTH;
    localparam int N    = W * W * W;
    localparam int IW   = $clog2(N);
    localparam int CB   = $clog2(W);
    localparam int CW   = $clog2(N + 1);
    localparam int SW   = IW + 1;
    localparam int PW   = 3 * CB;
    localparam logic [CB-1:0] CMAX     = CB'(W - 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(N - 1);
    localparam logic [CW-1:0] AIR_MAX  = CW'(N - W * W);

    localparam logic [2:0] D_PX  = 3'd0;
    localparam logic [2:0] D_PY  = 3'd1;
    localparam logic [2:0] D_PZ  = 3'd2;
    localparam logic [2:0] D_MX  = 3'd3;
    localparam logic [2:0] D_MY  = 3'd4;
    localparam logic [2:0] D_MZ  = 3'd5;
    localparam logic [2:0] D_END = 3'd6;

    typedef enum logic [9:0] {
        S_INIT  = 10'b00_0000_0001,
        S_IDLE  = 10'b00_0000_0010,
        S_RW    = 10'b00_0000_0100,
        S_CLR   = 10'b00_0000_1000,
        S_SCAN  = 10'b00_0001_0000,
        S_SCANW = 10'b00_0010_0000,
        S_NBR   = 10'b00_0100_0000,
        S_POP   = 10'b00_1000_0000,
        S_POPW  = 10'b01_0000_0000,
        S_FIN   = 10'b10_0000_0000
    } t_state;

    function automatic logic [IW-1:0] f_idx(input logic [CB-1:0] x, input logic [CB-1:0] y,
                                            input logic [CB-1:0] z);
        return IW'((32'(z) * W + 32'(y)) * W + 32'(x));
    endfunction

    t_state                     r_state, n_state;
    logic [IW-1:0]              r_addr, n_addr;
    logic [CB-1:0]              r_sx, n_sx, r_sy, n_sy, r_sz, n_sz;
    logic [CB-1:0]              r_cx, n_cx, r_cy, n_cy, r_cz, n_cz;
    logic [2:0]                 r_dir, n_dir;
    logic                       r_pend, n_pend;
    logic [PW-1:0]              r_pc, n_pc;
    logic [SW-1:0]              r_sp, n_sp;
    logic [CW-1:0]              r_found, n_found;
    logic [CW-1:0]              r_air, n_air;
    logic [vfc_pkg::FACES-1:0]  r_faces, n_faces;
    logic [vfc_pkg::MASK_W-1:0] r_mask, n_mask;
    logic [vfc_pkg::MASK_W-1:0] r_last, n_last;
    logic [vfc_pkg::MASK_W-1:0] mask_upd;
    logic [1:0]                 r_cmd, n_cmd;
    logic                       r_inside, n_inside;
    logic [IW-1:0]              r_idx, n_idx;
    logic [vfc_pkg::TYPE_W-1:0] r_type, n_type;
    logic [vfc_pkg::TYPE_W-1:0] r_rd, n_rd;

    logic                       blk_we, vis_we, stk_we;
    logic [IW-1:0]              blk_waddr, blk_raddr, vis_waddr, vis_raddr, stk_waddr, stk_raddr;
    logic [vfc_pkg::TYPE_W-1:0] blk_wdata, blk_rdata;
    logic                       vis_wdata, vis_rdata;
    logic [PW-1:0]              stk_rdata;

    logic                       in_inside;
    logic                       at_edge;
    logic [CB-1:0]              nx, ny, nz;
    logic                       last_seed;
    logic [CB-1:0]              px, py, pz;

    vfc_ram #(.DW(vfc_pkg::TYPE_W), .AW(IW)) u_blk (
        .i_clk(i_clk), .i_we(blk_we), .i_waddr(blk_waddr), .i_wdata(blk_wdata),
        .i_raddr(blk_raddr), .o_rdata(blk_rdata)
    );

    vfc_ram #(.DW(1), .AW(IW)) u_vis (
        .i_clk(i_clk), .i_we(vis_we), .i_waddr(vis_waddr), .i_wdata(vis_wdata),
        .i_raddr(vis_raddr), .o_rdata(vis_rdata)
    );

    vfc_ram #(.DW(PW), .AW(IW)) u_stk (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(stk_waddr), .i_wdata(r_pc),
        .i_raddr(stk_raddr), .o_rdata(stk_rdata)
    );

    assign in_inside = (32'(i_beat.pos_x) < W) && (32'(i_beat.pos_y) < W)
                    && (32'(i_beat.pos_z) < W);
    assign last_seed = (r_addr == LAST_IDX);
    assign mask_upd  = r_mask | vfc_pkg::pair_bits(r_faces);
    assign px        = r_pc[CB-1:0];
    assign py        = r_pc[2*CB-1:CB];
    assign pz        = r_pc[PW-1:2*CB];

    always_comb begin
        n_state  = r_state;
        n_addr   = r_addr;
        n_sx     = r_sx;
        n_sy     = r_sy;
        n_sz     = r_sz;
        n_cx     = r_cx;
        n_cy     = r_cy;
        n_cz     = r_cz;
        n_dir    = r_dir;
        n_pend   = r_pend;
        n_pc     = r_pc;
        n_sp     = r_sp;
        n_found  = r_found;
        n_air    = r_air;
        n_faces  = r_faces;
        n_mask   = r_mask;
        n_last   = r_last;
        n_cmd    = r_cmd;
        n_inside = r_inside;
        n_idx    = r_idx;
        n_type   = r_type;
        n_rd     = r_rd;

        blk_we    = 1'b0;
        blk_waddr = r_addr;
        blk_wdata = '0;
        blk_raddr = r_addr;
        vis_we    = 1'b0;
        vis_waddr = r_addr;
        vis_wdata = 1'b0;
        vis_raddr = r_addr;
        stk_we    = 1'b0;
        stk_waddr = r_sp[IW-1:0];
        stk_raddr = r_sp[IW-1:0];

        at_edge = 1'b1;
        nx      = r_cx;
        ny      = r_cy;
        nz      = r_cz;
        case (r_dir)
            D_PX: begin
                at_edge = (r_cx == CMAX);
                nx      = r_cx + CB'(1);
            end
            D_PY: begin
                at_edge = (r_cy == CMAX);
                ny      = r_cy + CB'(1);
            end
            D_PZ: begin
                at_edge = (r_cz == CMAX);
                nz      = r_cz + CB'(1);
            end
            D_MX: begin
                at_edge = (r_cx == '0);
                nx      = r_cx - CB'(1);
            end
            D_MY: begin
                at_edge = (r_cy == '0);
                ny      = r_cy - CB'(1);
            end
            D_MZ: begin
                at_edge = (r_cz == '0);
                nz      = r_cz - CB'(1);
            end
            default: begin
                at_edge = 1'b1;
            end
        endcase

        case (r_state)
            S_INIT: begin
                blk_we = 1'b1;
                n_addr = r_addr + IW'(1);
                if (last_seed) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                blk_raddr = f_idx(CB'(i_beat.pos_x), CB'(i_beat.pos_y), CB'(i_beat.pos_z));
                if (i_start) begin
                    n_cmd    = i_beat.cmd;
                    n_inside = in_inside;
                    n_idx    = blk_raddr;
                    n_type   = i_beat.block_type;
                    n_rd     = '0;
                    if (i_beat.cmd == vfc_pkg::CMD_COMPUTE) begin
                        if (r_air > AIR_MAX) begin
                            n_last  = vfc_pkg::ALL_PAIRS;
                            n_state = S_FIN;
                        end else begin
                            n_addr  = '0;
                            n_mask  = '0;
                            n_found = '0;
                            n_state = S_CLR;
                        end
                    end else begin
                        n_state = S_RW;
                    end
                end
            end
            S_RW: begin
                if (r_cmd == vfc_pkg::CMD_WRITE && r_inside && blk_rdata != r_type) begin
                    blk_we    = 1'b1;
                    blk_waddr = r_idx;
                    blk_wdata = r_type;
                    n_air     = (r_type == '0) ? r_air + CW'(1) : r_air - CW'(1);
                end
                if (r_cmd == vfc_pkg::CMD_READ && r_inside) begin
                    n_rd = blk_rdata;
                end
                n_state = S_FIN;
            end
            S_CLR: begin
                vis_we = 1'b1;
                n_addr = r_addr + IW'(1);
                if (last_seed) begin
                    n_addr  = '0;
                    n_sx    = '0;
                    n_sy    = '0;
                    n_sz    = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                n_state = S_SCANW;
            end
            S_SCANW: begin
                if (!vis_rdata && blk_rdata == '0) begin
                    vis_we    = 1'b1;
                    vis_wdata = 1'b1;
                    n_cx      = r_sx;
                    n_cy      = r_sy;
                    n_cz      = r_sz;
                    n_found   = r_found + CW'(1);
                    n_faces   = '0;
                    n_sp      = '0;
                    n_dir     = D_PX;
                    n_pend    = 1'b0;
                    n_state   = S_NBR;
                end else if (last_seed) begin
                    n_last  = r_mask;
                    n_state = S_FIN;
                end else begin
                    n_state = S_SCAN;
                end
                if (!(!vis_rdata && blk_rdata == '0) && !last_seed) begin
                    n_addr = r_addr + IW'(1);
                    n_sx   = (r_sx == CMAX) ? '0 : r_sx + CB'(1);
                    if (r_sx == CMAX) begin
                        n_sy = (r_sy == CMAX) ? '0 : r_sy + CB'(1);
                        if (r_sy == CMAX) begin
                            n_sz = r_sz + CB'(1);
                        end
                    end
                end
            end
            S_NBR: begin
                if (r_pend && blk_rdata == '0 && !vis_rdata) begin
                    vis_we    = 1'b1;
                    vis_waddr = f_idx(px, py, pz);
                    vis_wdata = 1'b1;
                    stk_we    = 1'b1;
                    n_sp      = r_sp + SW'(1);
                end
                n_pend = 1'b0;
                if (r_dir == D_END) begin
                    n_state = S_POP;
                end else begin
                    n_dir = r_dir + 3'd1;
                    if (at_edge) begin
                        n_faces[r_dir] = 1'b1;
                    end else begin
                        blk_raddr = f_idx(nx, ny, nz);
                        vis_raddr = blk_raddr;
                        n_pc      = {nz, ny, nx};
                        n_pend    = 1'b1;
                    end
                end
            end
            S_POP: begin
                if (r_sp == '0) begin
                    n_mask = mask_upd;
                    if (r_found >= r_air || last_seed) begin
                        n_last  = mask_upd;
                        n_state = S_FIN;
                    end else begin
                        n_addr  = r_addr + IW'(1);
                        n_sx    = (r_sx == CMAX) ? '0 : r_sx + CB'(1);
                        if (r_sx == CMAX) begin
                            n_sy = (r_sy == CMAX) ? '0 : r_sy + CB'(1);
                            if (r_sy == CMAX) begin
                                n_sz = r_sz + CB'(1);
                            end
                        end
                        n_state = S_SCAN;
                    end
                end else begin
                    stk_raddr = r_sp[IW-1:0] - IW'(1);
                    n_sp      = r_sp - SW'(1);
                    n_state   = S_POPW;
                end
            end
            S_POPW: begin
                n_cx    = stk_rdata[CB-1:0];
                n_cy    = stk_rdata[2*CB-1:CB];
                n_cz    = stk_rdata[PW-1:2*CB];
                n_found = r_found + CW'(1);
                n_dir   = D_PX;
                n_pend  = 1'b0;
                n_state = S_NBR;
            end
            S_FIN: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_addr  <= '0;
            r_air   <= CW'(N);
            r_last  <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_air   <= n_air;
            r_last  <= n_last;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sx     <= n_sx;
        r_sy     <= n_sy;
        r_sz     <= n_sz;
        r_cx     <= n_cx;
        r_cy     <= n_cy;
        r_cz     <= n_cz;
        r_dir    <= n_dir;
        r_pc     <= n_pc;
        r_sp     <= n_sp;
        r_found  <= n_found;
        r_faces  <= n_faces;
        r_mask   <= n_mask;
        r_cmd    <= n_cmd;
        r_inside <= n_inside;
        r_idx    <= n_idx;
        r_type   <= n_type;
        r_rd     <= n_rd;
    end

    assign o_idle             = (r_state == S_IDLE);
    assign o_done             = (r_state == S_FIN) && i_out_free;
    assign o_result.read_type = r_rd;
    assign o_result.pass_mask = r_last;
    assign o_result.air_total = vfc_pkg::AIR_W'(r_air);

endmodule

// File: hdl/voxel_face_connectivity.sv
// Voxel cube store with air count and face-pair connectivity compute.
// Top level: input handshake and output register. Depends on vfc_pkg, vfc_ctrl.
//
// Use: one command beat on the input channel (valid/ready) gives one result beat
// on the output channel. Write stores a block type and updates the air count,
// read returns the stored type, compute floods every air region and returns the
// face-pair mask. Every result carries the current mask and air count.
// Steps: read and write pass through S_RW and S_FIN, then the output register.
// Compute with fewer than CUBE_WIDTH^2 solid blocks returns all pairs without a
// flood; otherwise it clears the visited RAM (CUBE_WIDTH^3 entries, 4096 by
// default), then scans the seeds and walks each air block with one stack pop
// plus six neighbor probes on the single read port of the block RAM, ending
// early once all air is found.
// One command is in work at a time; a new one is taken while the last result
// waits in the output register.
// Reset: the block RAM is swept to air with input ready low; the air count
// resets to the full cube and the mask to zero.
// Stall: a result held by a low i_out_ready keeps the next command in its
// final state, S_FIN, until the output register frees.
module voxel_face_connectivity #(
    parameter int CUBE_WIDTH = vfc_pkg::CUBE_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  vfc_pkg::t_in_beat  i_in_data,
    output logic               o_in_ready,
    output logic               o_out_valid,
    output vfc_pkg::t_out_beat o_out_data,
    input  logic               i_out_ready
);

    logic               r_ovld, n_ovld;
    vfc_pkg::t_out_beat r_odata, n_odata;
    logic               idle, done, out_free;
    vfc_pkg::t_out_beat result;

    assign out_free = !r_ovld || i_out_ready;

    vfc_ctrl #(.CUBE_WIDTH(CUBE_WIDTH)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_in_valid && idle),
        .i_beat     (i_in_data),
        .i_out_free (out_free),
        .o_idle     (idle),
        .o_done     (done),
        .o_result   (result)
    );

    always_comb begin
        n_ovld  = r_ovld;
        n_odata = r_odata;
        if (done) begin
            n_ovld  = 1'b1;
            n_odata = result;
        end else if (i_out_ready) begin
            n_ovld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else begin
            r_ovld <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_odata <= n_odata;
    end

    assign o_in_ready  = idle;
    assign o_out_valid = r_ovld;
    assign o_out_data  = r_odata;

endmodule

// File: test/tb_top.sv
// Testbench for voxel_face_connectivity: drives write, read, compute and unused command
// beats with random idling and checks every result against a behavioral cube model. Depends on vfc_pkg.
module tb_top;

    localparam int W     = vfc_pkg::CUBE_WIDTH_DEF;
    localparam int CELLS = W * W * W;
    localparam int WATCH = 200000;
    localparam logic [1:0] CMD_NONE = 2'd3;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    vfc_pkg::t_in_beat  i_in_data;
    logic               o_in_ready;
    logic               o_out_valid;
    vfc_pkg::t_out_beat o_out_data;
    logic               i_out_ready;

    voxel_face_connectivity DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_ready (o_in_ready),
        .o_out_valid(o_out_valid),
        .o_out_data (o_out_data),
        .i_out_ready(i_out_ready)
    );

    logic [vfc_pkg::TYPE_W-1:0] cube_types [CELLS];
    int unsigned                air_cnt;
    logic [vfc_pkg::MASK_W-1:0] mask_reg;
    bit                         seen [CELLS];
    int unsigned                fill_stack [$];

    vfc_pkg::t_in_beat  cmd_queue [$];
    vfc_pkg::t_out_beat result_queue [$];
    int        fails;
    int        idle_cnt;
    int        hold_cnt;
    int        wd_cnt;
    bit        feed_done;
    bit        calm;
    bit        pause_req;
    bit        sender_paused;

    function automatic logic [vfc_pkg::MASK_W-1:0] face_pairs(
        input logic [vfc_pkg::FACES-1:0] f);
        logic [vfc_pkg::MASK_W-1:0] m;
        int                         k;
        m = '0;
        k = 0;
        for (int a = 0; a < vfc_pkg::FACES - 1; a++) begin
            for (int b = a + 1; b < vfc_pkg::FACES; b++) begin
                if (f[a] && f[b]) m[k] = 1'b1;
                k++;
            end
        end
        return m;
    endfunction

    function automatic logic [vfc_pkg::MASK_W-1:0] flood_mask();
        logic [vfc_pkg::MASK_W-1:0] m;
        logic [vfc_pkg::FACES-1:0]  f;
        int unsigned                found, cur, ni;
        int                         c [3];
        int                         n [3];
        int                         ax;
        m = '0;
        found = 0;
        if (air_cnt > CELLS - W * W) return vfc_pkg::ALL_PAIRS;
        foreach (seen[i]) seen[i] = 0;
        for (int s = 0; s < CELLS; s++) begin
            if (seen[s]) continue;
            seen[s] = 1;
            if (cube_types[s] != 0) continue;
            f = '0;
            fill_stack.delete();
            fill_stack.push_back(s);
            while (fill_stack.size() > 0) begin
                cur = fill_stack.pop_back();
                found++;
                c[0] = cur % W;
                c[1] = (cur / W) % W;
                c[2] = cur / (W * W);
                for (int d = 0; d < vfc_pkg::FACES; d++) begin
                    ax = d % 3;
                    if (c[ax] == ((d < 3) ? W - 1 : 0)) begin
                        f[d] = 1'b1;
                        continue;
                    end
                    n = c;
                    n[ax] = (d < 3) ? n[ax] + 1 : n[ax] - 1;
                    ni = (n[2] * W + n[1]) * W + n[0];
                    if (cube_types[ni] == 0 && !seen[ni]) begin
                        seen[ni] = 1;
                        fill_stack.push_back(ni);
                    end
                end
            end
            m |= face_pairs(f);
            if (found >= air_cnt) break;
        end
        return m;
    endfunction

    function automatic vfc_pkg::t_out_beat predict_result(input vfc_pkg::t_in_beat b);
        vfc_pkg::t_out_beat r;
        int unsigned        idx;
        idx = (int'(b.pos_z) * W + int'(b.pos_y)) * W + int'(b.pos_x);
        r = '0;
        case (b.cmd)
            vfc_pkg::CMD_WRITE: begin
                if (cube_types[idx] != b.block_type) begin
                    cube_types[idx] = b.block_type;
                    if (b.block_type == 0) air_cnt++;
                    else air_cnt--;
                end
            end
            vfc_pkg::CMD_READ: r.read_type = cube_types[idx];
            vfc_pkg::CMD_COMPUTE: mask_reg = flood_mask();
            default: ;
        endcase
        r.pass_mask = mask_reg;
        r.air_total = air_cnt[vfc_pkg::AIR_W-1:0];
        return r;
    endfunction

    function automatic vfc_pkg::t_in_beat mk(input logic [1:0] c, input int x, input int y,
                                             input int z, input int t);
        vfc_pkg::t_in_beat b;
        b.cmd = c;
        b.pos_x = vfc_pkg::POS_W'(x);
        b.pos_y = vfc_pkg::POS_W'(y);
        b.pos_z = vfc_pkg::POS_W'(z);
        b.block_type = vfc_pkg::TYPE_W'(t);
        return b;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        int k;
        int n;
        int pat;
        int h;
        i_rst_n = 1'b0;
        pause_req = 0;
        foreach (cube_types[i]) cube_types[i] = '0;
        air_cnt = CELLS;
        mask_reg = '0;
        // directed: empty cube, field extremes, unused command, read back
        cmd_queue.push_back(mk(vfc_pkg::CMD_COMPUTE, 0, 0, 0, 0));
        cmd_queue.push_back(mk(vfc_pkg::CMD_WRITE, 15, 15, 15, 255));
        cmd_queue.push_back(mk(vfc_pkg::CMD_READ, 15, 15, 15, 0));
        cmd_queue.push_back(mk(vfc_pkg::CMD_WRITE, 15, 15, 15, 255));
        cmd_queue.push_back(mk(vfc_pkg::CMD_WRITE, 0, 0, 0, 1));
        cmd_queue.push_back(mk(vfc_pkg::CMD_READ, 0, 0, 0, 170));
        cmd_queue.push_back(mk(CMD_NONE, 10, 5, 10, 85));
        cmd_queue.push_back(mk(vfc_pkg::CMD_WRITE, 15, 15, 15, 0));
        cmd_queue.push_back(mk(vfc_pkg::CMD_READ, 15, 15, 15, 255));
        // solid wall at x = 7: splits the cube, then a hole joins it again
        for (int y = 0; y < W; y++)
            for (int z = 0; z < W; z++)
                cmd_queue.push_back(mk(vfc_pkg::CMD_WRITE, 7, y, z, 3));
        cmd_queue.push_back(mk(vfc_pkg::CMD_COMPUTE, 0, 0, 0, 0));
        cmd_queue.push_back(mk(vfc_pkg::CMD_WRITE, 7, 4, 9, 0));
        cmd_queue.push_back(mk(vfc_pkg::CMD_COMPUTE, 1, 2, 3, 4));
        cmd_queue.push_back(mk(vfc_pkg::CMD_WRITE, 7, 4, 9, 9));
        // random: half writes (a third of them on the wall plane), reads, computes, some noise
        for (int i = 0; i < 100; i++) begin
            k = $urandom_range(0, 9);
            if (k < 5) begin
                pat = $urandom_range(0, 2);
                h = (pat == 0) ? 7 : $urandom_range(0, 15);
                n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 255);
                cmd_queue.push_back(mk(vfc_pkg::CMD_WRITE, h, $urandom_range(0, 15),
                                       $urandom_range(0, 15), n));
            end else if (k < 7) begin
                cmd_queue.push_back(mk(vfc_pkg::CMD_READ, $urandom_range(0, 15),
                                       $urandom_range(0, 15), $urandom_range(0, 15),
                                       $urandom_range(0, 255)));
            end else if (k < 9) begin
                cmd_queue.push_back(mk(vfc_pkg::CMD_COMPUTE, $urandom_range(0, 15),
                                       $urandom_range(0, 15), $urandom_range(0, 15),
                                       $urandom_range(0, 255)));
            end else begin
                cmd_queue.push_back(mk(CMD_NONE, $urandom_range(0, 15),
                                       $urandom_range(0, 15), $urandom_range(0, 15),
                                       $urandom_range(0, 255)));
            end
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (cmd_queue.size() < 60);
        pause_req = 1;
        wait (sender_paused && result_queue.size() == 0);
        pause_req = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid    <= 1'b0;
            i_in_data     <= '0;
            idle_cnt      <= 0;
            feed_done     <= 0;
            sender_paused <= 0;
        end else begin
            if (i_in_valid && o_in_ready)
                result_queue.push_back(predict_result(i_in_data));
            if (!i_in_valid || o_in_ready) begin
                if (pause_req) begin
                    i_in_valid    <= 1'b0;
                    sender_paused <= 1;
                end else begin
                    sender_paused <= 0;
                    if (idle_cnt > 0) begin
                        i_in_valid <= 1'b0;
                        idle_cnt   <= idle_cnt - 1;
                    end else if (cmd_queue.size() > 0) begin
                        if (!calm && $urandom_range(0, 5) == 0) begin
                            i_in_valid <= 1'b0;
                            idle_cnt   <= $urandom_range(0, 17);
                        end else begin
                            i_in_valid <= 1'b1;
                            i_in_data  <= cmd_queue.pop_front();
                        end
                    end else begin
                        i_in_valid <= 1'b0;
                        feed_done  <= 1;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            hold_cnt    <= 5000;
        end else if (hold_cnt > 0) begin
            // hold off past the reset sweep so the sender backs up
            i_out_ready <= 1'b0;
            hold_cnt    <= hold_cnt - 1;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            i_out_ready <= 1'b0;
            hold_cnt    <= $urandom_range(0, 17);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    assign calm = cmd_queue.size() < 20;

    always @(posedge i_clk) begin
        vfc_pkg::t_out_beat e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (result_queue.size() == 0) begin
                $display("%0t: unexpected result, actual %h", $time, o_out_data);
                fails++;
            end else begin
                e = result_queue.pop_front();
                if (o_out_data.read_type !== e.read_type) begin
                    $display("%0t: read_type expected %h actual %h", $time,
                             e.read_type, o_out_data.read_type);
                    fails++;
                end
                if (o_out_data.pass_mask !== e.pass_mask) begin
                    $display("%0t: pass_mask expected %h actual %h", $time,
                             e.pass_mask, o_out_data.pass_mask);
                    fails++;
                end
                if (o_out_data.air_total !== e.air_total) begin
                    $display("%0t: air_total expected %0d actual %0d", $time,
                             e.air_total, o_out_data.air_total);
                    fails++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            wd_cnt <= 0;
        else
            wd_cnt <= wd_cnt + 1;
    end

    initial begin
        fails = 0;
        wait (feed_done && result_queue.size() == 0);
        repeat (50) @(posedge i_clk);
        if (fails == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

    initial begin
        wait (wd_cnt >= WATCH);
        $display("FAILURE");
        $finish;
    end

endmodule
